// ===== sv/cdre_pkg.sv =====
// ----------------------------------------------------------------------------
// cdre_pkg
// Shared constants, codes and control structs for the CSR row expander.
// ----------------------------------------------------------------------------
package cdre_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int CNT_W       = 7;
   localparam int ROW_W       = 16;
   localparam int PTR_W       = 32;
   localparam int VAL_W       = 64;
   localparam int ST_W        = 2;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;

   localparam logic CMD_POINTER = 1'b0;
   localparam logic CMD_NONZERO = 1'b1;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_BAD_COL  = 2'd1;
   localparam logic [ST_W-1:0] ST_PTR_DEC  = 2'd2;
   localparam logic [ST_W-1:0] ST_NO_ROW   = 2'd3;

   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   typedef struct packed {
      logic take;
      logic rd_first;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic drain_req;
      logic out_free;
      logic last_col;
   } dp_sts_type;

   function automatic logic [CNT_W-1:0] eff_cols(input logic [CNT_W-1:0] cc);
      logic [CNT_W-1:0] n;
      n = cc;
      if (cc == '0) n = CNT_W'(1);
      else if (cc > CNT_W'(MAX_COLUMNS)) n = CNT_W'(MAX_COLUMNS);
      return n;
   endfunction

   function automatic logic [ROW_W-1:0] eff_rows(input logic [ROW_W-1:0] rc);
      return (rc == '0) ? ROW_W'(1) : rc;
   endfunction

endpackage

// ===== sv/cdre_req_if.sv =====
// ----------------------------------------------------------------------------
// cdre_req_if
// Input channel: row pointer or nonzero beats with valid/ready.
// ----------------------------------------------------------------------------
interface cdre_req_if;
   import cdre_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [PTR_W-1:0] row_pointer;
   logic [COL_W-1:0] column;
   logic [VAL_W-1:0] value;

   modport source (output valid, command, row_pointer, column, value, input ready);
   modport sink   (input valid, command, row_pointer, column, value, output ready);
endinterface

// ===== sv/cdre_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cdre_rsp_if
// Result channel: dense element and status beats with valid/ready.
// ----------------------------------------------------------------------------
interface cdre_rsp_if;
   import cdre_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] element;
   logic [ROW_W-1:0] row_number;
   logic [COL_W-1:0] column_number;
   logic             last_in_row;
   logic             last_in_matrix;
   logic [ST_W-1:0]  status;

   modport source (output valid, element, row_number, column_number, last_in_row,
                   last_in_matrix, status, input ready);
   modport sink   (input valid, element, row_number, column_number, last_in_row,
                   last_in_matrix, status, output ready);
endinterface

// ===== sv/cdre_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdre_ctrl
// Sequencer: takes input beats, then reads and emits a finished row.
// ----------------------------------------------------------------------------
module cdre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  cdre_pkg::dp_sts_type sts,
   output cdre_pkg::dp_cmd_type cmd
);
   import cdre_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.drain_req) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free && sts.last_col) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign cmd.take     = (state_ff == S_IDLE);
   assign cmd.rd_first = (state_ff == S_READ);
   assign cmd.emit     = (state_ff == S_EMIT);

endmodule

// ===== sv/cdre_dp.sv =====
// ----------------------------------------------------------------------------
// cdre_dp
// Datapath: row state, row buffer with per-entry valid bits, result register.
// ----------------------------------------------------------------------------
module cdre_dp (
   input  logic                             clock,
   input  logic                             reset,
   cdre_req_if.sink                         req,
   cdre_rsp_if.source                       rsp,
   input  logic [cdre_pkg::ROW_W-1:0]       row_count,
   input  logic [cdre_pkg::CNT_W-1:0]       column_count,
   input  cdre_pkg::dp_cmd_type             cmd,
   output cdre_pkg::dp_sts_type             sts
);
   import cdre_pkg::*;

   logic [VAL_W-1:0]       mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] vld_ff;
   logic [VAL_W-1:0]       rdata_ff;
   logic                   rvld_ff;

   logic [PTR_W-1:0] prev_ff, prev_in;
   logic [PTR_W-1:0] rem_ff, rem_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             base_ff, base_in;
   logic             open_ff, open_in;
   logic [ST_W-1:0]  code_ff, code_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic             ov_ff, ov_in;
   logic [VAL_W-1:0] o_elem_ff, o_elem_in;
   logic [ROW_W-1:0] o_row_ff, o_row_in;
   logic [COL_W-1:0] o_col_ff, o_col_in;
   logic             o_lr_ff, o_lr_in;
   logic             o_lm_ff, o_lm_in;
   logic [ST_W-1:0]  o_st_ff, o_st_in;

   logic             out_free, acc, bad, mem_we, rd_en, emit_fire, last_col;
   logic             last_matrix, finish, stat_load, drain_req;
   logic [ST_W-1:0]  stat_code;
   logic [CNT_W-1:0] ncol;
   logic [COL_W-1:0] rd_addr;

   always_comb begin
      out_free    = !ov_ff || rsp.ready;
      acc         = cmd.take && out_free && req.valid;
      ncol        = eff_cols(column_count);
      bad         = {1'b0, req.column} >= ncol;
      last_col    = col_ff == COL_W'(ncol - CNT_W'(1));
      emit_fire   = cmd.emit && out_free;
      finish      = emit_fire && last_col;
      last_matrix = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, eff_rows(row_count)};

      prev_in   = prev_ff;
      rem_in    = rem_ff;
      row_in    = row_ff;
      base_in   = base_ff;
      open_in   = open_ff;
      code_in   = code_ff;
      mem_we    = 1'b0;
      stat_load = 1'b0;
      stat_code = ST_OK;
      drain_req = 1'b0;

      if (acc) begin
         case (req.command)
            CMD_POINTER: begin
               if (!base_ff) begin
                  prev_in = req.row_pointer;
                  base_in = 1'b1;
               end else if (!open_ff) begin
                  if (req.row_pointer < prev_ff) begin
                     stat_load = 1'b1;
                     stat_code = ST_PTR_DEC;
                  end else begin
                     rem_in  = req.row_pointer - prev_ff;
                     prev_in = req.row_pointer;
                     open_in = 1'b1;
                     if (req.row_pointer == prev_ff) begin
                        drain_req = 1'b1;
                        code_in   = ST_OK;
                     end
                  end
               end
            end
            CMD_NONZERO: begin
               if (!open_ff) begin
                  stat_load = 1'b1;
                  stat_code = ST_NO_ROW;
               end else begin
                  mem_we = !bad;
                  rem_in = rem_ff - PTR_W'(1);
                  if (rem_ff == PTR_W'(1)) begin
                     drain_req = 1'b1;
                     code_in   = bad ? ST_BAD_COL : ST_OK;
                  end else if (bad) begin
                     stat_load = 1'b1;
                     stat_code = ST_BAD_COL;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (finish) begin
         open_in = 1'b0;
         rem_in  = '0;
         if (last_matrix) begin
            row_in  = '0;
            base_in = 1'b0;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end

      rd_en   = cmd.rd_first || (emit_fire && !last_col);
      rd_addr = cmd.rd_first ? '0 : col_ff + COL_W'(1);
      col_in  = col_ff;
      if (cmd.rd_first) col_in = '0;
      else if (emit_fire) col_in = col_ff + COL_W'(1);

      ov_in     = ov_ff && !rsp.ready;
      o_elem_in = o_elem_ff;
      o_row_in  = o_row_ff;
      o_col_in  = o_col_ff;
      o_lr_in   = o_lr_ff;
      o_lm_in   = o_lm_ff;
      o_st_in   = o_st_ff;
      if (emit_fire) begin
         ov_in     = 1'b1;
         o_elem_in = rvld_ff ? rdata_ff : '0;
         o_row_in  = row_ff;
         o_col_in  = col_ff;
         o_lr_in   = last_col;
         o_lm_in   = last_col && last_matrix;
         o_st_in   = code_ff;
      end else if (stat_load) begin
         ov_in     = 1'b1;
         o_elem_in = '0;
         o_row_in  = row_ff;
         o_col_in  = '0;
         o_lr_in   = 1'b0;
         o_lm_in   = 1'b0;
         o_st_in   = stat_code;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[req.column] <= req.value;
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         rvld_ff  <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[req.column] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         rem_ff  <= '0;
         row_ff  <= '0;
         base_ff <= 1'b0;
         open_ff <= 1'b0;
         code_ff <= ST_OK;
         col_ff  <= '0;
         ov_ff   <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         rem_ff  <= rem_in;
         row_ff  <= row_in;
         base_ff <= base_in;
         open_ff <= open_in;
         code_ff <= code_in;
         col_ff  <= col_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      o_elem_ff <= o_elem_in;
      o_row_ff  <= o_row_in;
      o_col_ff  <= o_col_in;
      o_lr_ff   <= o_lr_in;
      o_lm_ff   <= o_lm_in;
      o_st_ff   <= o_st_in;
   end

   assign req.ready          = cmd.take && out_free;
   assign rsp.valid          = ov_ff;
   assign rsp.element        = o_elem_ff;
   assign rsp.row_number     = o_row_ff;
   assign rsp.column_number  = o_col_ff;
   assign rsp.last_in_row    = o_lr_ff;
   assign rsp.last_in_matrix = o_lm_ff;
   assign rsp.status         = o_st_ff;

   assign sts.drain_req = drain_req;
   assign sts.out_free  = out_free;
   assign sts.last_col  = last_col;

endmodule

// ===== sv/csr_to_dense_row_expander.sv =====
// ----------------------------------------------------------------------------
// csr_to_dense_row_expander
// Expands a CSR pointer/nonzero stream into dense row-major element beats.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while no row drains and output is free;
// status beats come out in the cycle after the causing input beat. A row-closing
// beat stalls input while its row drains: column 0 is read, then n buffer words
// (n the effective column count) leave one per cycle while output is free. Reset:
// synchronous; control state and buffer valid bits clear at once, so the row
// buffer reads as zero with no clearing pass. Registers: rows 1, cols 64.
module csr_to_dense_row_expander (
   input  logic                          clock,
   input  logic                          reset,
   cdre_req_if.sink                      req_bus,
   cdre_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cdre_pkg::ADDR_W-1:0]   paddr,
   input  logic [cdre_pkg::DATA_W-1:0]   pwdata,
   output logic [cdre_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import cdre_pkg::*;

   logic [ROW_W-1:0] row_count_ff;
   logic [CNT_W-1:0] column_count_ff;
   logic             wr_en;
   dp_cmd_type       cmd;
   dp_sts_type       sts;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_W'(1);
         column_count_ff <= CNT_W'(MAX_COLUMNS);
      end else if (wr_en) begin
         case (paddr[2])
            REG_ROW_COUNT:    row_count_ff    <= pwdata[ROW_W-1:0];
            REG_COLUMN_COUNT: column_count_ff <= pwdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ROW_COUNT:    prdata = DATA_W'(row_count_ff);
         REG_COLUMN_COUNT: prdata = DATA_W'(column_count_ff);
         default:          prdata = '0;
      endcase
   end

   cdre_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   cdre_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .row_count    (row_count_ff),
      .column_count (column_count_ff),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule
